### sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the five-point sharpen filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  // register indexes on the config port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // red in the low byte, matching the stream data layout
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic frame_end;
    pix_t pix;
  } res_t;

  // neighborhood around the pixel one row up from the incoming one
  typedef struct packed {
    pix_t up;
    pix_t left;
    pix_t center;
    pix_t right;
  } win_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           room;
  } q_stat_t;

endpackage

`default_nettype wire

### sv/sps_lane.sv
// ----------------------------------------------------------------------------
// sps_lane
// One color channel of the cross kernel: 5*center - four neighbors, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_lane (
  input  wire logic [sps_pkg::CH_W-1:0] ctr,
  input  wire logic [sps_pkg::CH_W-1:0] up,
  input  wire logic [sps_pkg::CH_W-1:0] left,
  input  wire logic [sps_pkg::CH_W-1:0] right,
  input  wire logic [sps_pkg::CH_W-1:0] down,
  output logic      [sps_pkg::CH_W-1:0] sharp
);

  logic        [10:0] five;
  logic        [9:0]  nsum;
  logic signed [11:0] diff;

  assign five = {1'b0, ctr, 2'b00} + {3'b000, ctr};
  assign nsum = {2'b00, up} + {2'b00, left} + {2'b00, right} + {2'b00, down};
  assign diff = $signed({1'b0, five}) - $signed({2'b00, nsum});

  always_comb begin
    if (diff < 0) begin
      sharp = '0;
    end else if (diff > 12'sd255) begin
      sharp = '1;
    end else begin
      sharp = diff[7:0];
    end
  end

endmodule

`default_nettype wire

### sv/sps_line_buf.sv
// ----------------------------------------------------------------------------
// sps_line_buf
// Two line stores with registered reads and the pixel window around them.
// Reads run ahead of the column so the window is ready on the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_line_buf #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          acc,
  input  wire logic [AW-1:0] col,
  input  wire logic [AW-1:0] mid_rd_addr,
  input  wire logic [AW-1:0] up_rd_addr,
  input  wire sps_pkg::pix_t px,
  output sps_pkg::win_t      win
);

  sps_pkg::pix_t upper_mem  [MAX_WIDTH];
  sps_pkg::pix_t middle_mem [MAX_WIDTH];

  sps_pkg::pix_t mid_rd;
  sps_pkg::pix_t up_rd;
  sps_pkg::pix_t center;
  sps_pkg::pix_t left;

  // center is the previous look-ahead read; left is the center before it
  always_ff @(posedge clk) begin
    if (acc) begin
      upper_mem[col]  <= center;
      middle_mem[col] <= px;
      mid_rd          <= middle_mem[mid_rd_addr];
      up_rd           <= upper_mem[up_rd_addr];
      center          <= mid_rd;
      left            <= center;
    end
  end

  assign win.up     = up_rd;
  assign win.left   = left;
  assign win.center = center;
  assign win.right  = mid_rd;

endmodule

`default_nettype wire

### sv/sps_out_queue.sv
// ----------------------------------------------------------------------------
// sps_out_queue
// Small result queue, up to two writes per cycle, one read.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_out_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sps_pkg::push_t push,
  input  wire logic           pop,
  output sps_pkg::res_t       head,
  output sps_pkg::q_stat_t    stat
);

  sps_pkg::res_t slot [sps_pkg::QDEPTH];

  logic [sps_pkg::QAW-1:0] wr_ptr;
  logic [sps_pkg::QAW-1:0] rd_ptr;
  logic [sps_pkg::QCW-1:0] count;
  logic [sps_pkg::QCW-1:0] count_next;
  logic [sps_pkg::QAW-1:0] wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + sps_pkg::QAW'(1);
  assign count_next = count + sps_pkg::QCW'(push.cnt) - sps_pkg::QCW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slot[wr_ptr] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      slot[wr_ptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sps_pkg::QAW'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + sps_pkg::QAW'(1);
      end
      count <= count_next;
    end
  end

  assign head       = slot[rd_ptr];
  assign stat.count = count;
  assign stat.room  = (count <= sps_pkg::QCW'(sps_pkg::QDEPTH - 2));

endmodule

`default_nettype wire

### sv/five_point_sharpen_filter.sv
// ----------------------------------------------------------------------------
// five_point_sharpen_filter
// Cross-kernel sharpening of a raster RGB stream, output one row behind.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  s_*      in   s_tvalid / s_tready     s_tdata: red, green, blue
//  m_*      out  m_tvalid / m_tready     m_tdata: red, green, blue; m_tlast
//  apb      in   psel/penable/pready     image_width @0x0, image_height @0x4
//
//  One pixel request per clock while the result queue has room; results are
//  registered in the result queue. On the last row each request gives two
//  results, so the single output port limits the input rate there.
//  The input stalls when fewer than two result queue slots are free.
//  Reset clears counters and queue; line stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module five_point_sharpen_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in: [7:0] red, [15:8] green, [23:16] blue
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  // stream out: [7:0] red, [15:8] green, [23:16] blue
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,
  output logic             m_tlast,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  function automatic logic [CW-1:0] eff_w_last(input logic [11:0] v);
    int w;
    w = int'(v);
    if (w < sps_pkg::MIN_DIM) w = sps_pkg::MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return CW'(w - 1);
  endfunction

  function automatic logic [sps_pkg::ROW_W-1:0] eff_h_last(input logic [12:0] v);
    int h;
    h = int'(v);
    if (h < sps_pkg::MIN_DIM) h = sps_pkg::MIN_DIM;
    if (h > sps_pkg::MAX_HEIGHT) h = sps_pkg::MAX_HEIGHT;
    return sps_pkg::ROW_W'(h - 1);
  endfunction

  logic [11:0]               width_reg;
  logic [12:0]               height_reg;
  logic [CW-1:0]             w_last;
  logic [sps_pkg::ROW_W-1:0] h_last;
  logic [CW-1:0]             col;
  logic [sps_pkg::ROW_W-1:0] row;

  logic          cfg_wr;
  logic          acc;
  logic          last_col;
  logic          last_row;
  logic [CW:0]   col_plus2;
  logic [CW-1:0] mid_rd_addr;
  logic [CW-1:0] up_rd_addr;

  sps_pkg::pix_t    px;
  sps_pkg::win_t    win;
  sps_pkg::pix_t    sharp_pix;
  sps_pkg::res_t    res0;
  sps_pkg::res_t    res1;
  sps_pkg::push_t   push;
  sps_pkg::res_t    head;
  sps_pkg::q_stat_t q_stat;

  logic [2:0][sps_pkg::CH_W-1:0] up_ch, left_ch, ctr_ch, right_ch, down_ch, sharp_ch;
  logic emit0, emit1, border;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      sps_pkg::REG_WIDTH:  prdata = {20'd0, width_reg};
      sps_pkg::REG_HEIGHT: prdata = {19'd0, height_reg};
      default:             prdata = '0;
    endcase
  end

  // ---------------- position tracking ----------------
  assign acc      = s_tvalid & s_tready;
  assign last_col = (col == w_last);
  assign last_row = (row == h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sps_pkg::WIDTH_RST;
      height_reg <= sps_pkg::HEIGHT_RST;
      w_last     <= eff_w_last(sps_pkg::WIDTH_RST);
      h_last     <= eff_h_last(sps_pkg::HEIGHT_RST);
      col        <= '0;
      row        <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        sps_pkg::REG_WIDTH: begin
          width_reg <= pwdata[11:0];
          w_last    <= eff_w_last(pwdata[11:0]);
        end
        sps_pkg::REG_HEIGHT: begin
          height_reg <= pwdata[12:0];
          h_last     <= eff_h_last(pwdata[12:0]);
        end
        default: begin
          width_reg <= width_reg;
        end
      endcase
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + sps_pkg::ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // look-ahead reads: middle two columns ahead, upper one ahead, wrapping
  assign col_plus2   = {1'b0, col} + (CW+1)'(2);
  assign mid_rd_addr = (col_plus2 > {1'b0, w_last}) ?
                       CW'(col_plus2 - {1'b0, w_last} - (CW+1)'(1)) : col_plus2[CW-1:0];
  assign up_rd_addr  = last_col ? '0 : col + CW'(1);

  assign px = sps_pkg::pix_t'(s_tdata);

  sps_line_buf #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (CW)
  ) u_line_buf (
    .clk        (clk),
    .acc        (acc),
    .col        (col),
    .mid_rd_addr(mid_rd_addr),
    .up_rd_addr (up_rd_addr),
    .px         (px),
    .win        (win)
  );

  // ---------------- channel lanes ----------------
  assign up_ch    = win.up;
  assign left_ch  = win.left;
  assign ctr_ch   = win.center;
  assign right_ch = win.right;
  assign down_ch  = px;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    sps_lane u_lane (
      .ctr  (ctr_ch[k]),
      .up   (up_ch[k]),
      .left (left_ch[k]),
      .right(right_ch[k]),
      .down (down_ch[k]),
      .sharp(sharp_ch[k])
    );
  end

  assign sharp_pix = sps_pkg::pix_t'(sharp_ch);

  // ---------------- merge into results ----------------
  assign emit0  = (row != '0);
  assign emit1  = last_row;
  assign border = (row == sps_pkg::ROW_W'(1)) | (col == '0) | last_col;

  always_comb begin
    res0.frame_end = 1'b0;
    res0.pix       = border ? win.center : sharp_pix;
    res1.frame_end = last_col;
    res1.pix       = px;
    push.cnt       = acc ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
    push.first     = emit0 ? res0 : res1;
    push.second    = res1;
  end

  sps_out_queue u_out_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .pop (m_tvalid & m_tready),
    .head(head),
    .stat(q_stat)
  );

  assign s_tready = q_stat.room;
  assign m_tvalid = (q_stat.count != '0);
  assign m_tdata  = head.pix;
  assign m_tlast  = head.frame_end;

  // ---------------- assertions ----------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= sps_pkg::QCW'(sps_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && last_row && last_col) |=> (row == '0 && col == '0))
    else $error("counters did not wrap at frame end");

  a_row0_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && row == '0) |=> (q_stat.count <= $past(q_stat.count)))
    else $error("first row produced a result");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !q_stat.room |-> (push.cnt == 2'd0))
    else $error("push while queue lacks room");

endmodule

`default_nettype wire

### tb/sv/five_point_sharpen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_sharpen_checker
// Watches the pixel streams and the config port of the sharpen filter. It
// keeps its own line stores and counters, predicts every output pixel of each
// accepted request and compares the outputs, in order, field by field.
// ----------------------------------------------------------------------------
module five_point_sharpen_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);

  logic [11:0]   width_reg;
  logic [12:0]   height_reg;
  sps_pkg::pix_t upper_row [MAX_WIDTH];
  sps_pkg::pix_t middle_row [MAX_WIDTH];
  int            col_pos;
  int            row_pos;
  sps_pkg::pix_t left_px;
  sps_pkg::res_t awaited_pixels[$];
  int            errs = 0;

  function automatic logic [7:0] sharpen_channel(input logic [7:0] u, l, c, r, d);
    int t;
    t = 5 * int'(c) - int'(u) - int'(l) - int'(r) - int'(d);
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic sps_pkg::pix_t sharpen_pixel(input sps_pkg::pix_t u, l, c, r, d);
    sps_pkg::pix_t p;
    p.red   = sharpen_channel(u.red,   l.red,   c.red,   r.red,   d.red);
    p.green = sharpen_channel(u.green, l.green, c.green, r.green, d.green);
    p.blue  = sharpen_channel(u.blue,  l.blue,  c.blue,  r.blue,  d.blue);
    return p;
  endfunction

  // one incoming pixel: from row 1 on emits the pixel one row up, plus itself on the last row
  task automatic filter_pixel(input sps_pkg::pix_t px);
    int            w;
    int            h;
    bit            last_row;
    bit            last_col;
    sps_pkg::pix_t mid;
    sps_pkg::pix_t up;
    sps_pkg::pix_t right;
    sps_pkg::pix_t res;
    w = width_reg;
    if (w < sps_pkg::MIN_DIM) w = sps_pkg::MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < sps_pkg::MIN_DIM) h = sps_pkg::MIN_DIM;
    if (h > sps_pkg::MAX_HEIGHT) h = sps_pkg::MAX_HEIGHT;
    last_row = (row_pos + 1 >= h);
    last_col = (col_pos + 1 >= w);
    mid   = middle_row[col_pos];
    up    = upper_row[col_pos];
    right = (col_pos + 1 < MAX_WIDTH) ? middle_row[col_pos + 1] : '0;
    if (row_pos >= 1) begin
      if (row_pos == 1 || col_pos == 0 || last_col)
        res = mid;
      else
        res = sharpen_pixel(up, left_px, mid, right, px);
      awaited_pixels.push_back({1'b0, res});
    end
    if (last_row) awaited_pixels.push_back({last_col, px});
    left_px             = mid;
    upper_row[col_pos]  = mid;
    middle_row[col_pos] = px;
    if (last_col) begin
      col_pos = 0;
      left_px = '0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_output(input sps_pkg::res_t got);
    sps_pkg::res_t want;
    if (awaited_pixels.size() == 0) begin
      $error("output pixel %h (last %0d) with none expected", got.pix, got.frame_end);
      errs++;
      return;
    end
    want = awaited_pixels.pop_front();
    if (got.pix.red !== want.pix.red) begin
      $error("red_out: expected %0d, got %0d", want.pix.red, got.pix.red);
      errs++;
    end
    if (got.pix.green !== want.pix.green) begin
      $error("green_out: expected %0d, got %0d", want.pix.green, got.pix.green);
      errs++;
    end
    if (got.pix.blue !== want.pix.blue) begin
      $error("blue_out: expected %0d, got %0d", want.pix.blue, got.pix.blue);
      errs++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = sps_pkg::WIDTH_RST;
      height_reg = sps_pkg::HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      left_px    = '0;
      awaited_pixels.delete();
    end else begin
      // any register write restarts the frame; line stores are kept
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == sps_pkg::REG_WIDTH)
          width_reg = pwdata[11:0];
        else
          height_reg = pwdata[12:0];
        col_pos = 0;
        row_pos = 0;
        left_px = '0;
      end
      if (s_tvalid && s_tready) filter_pixel(sps_pkg::pix_t'(s_tdata));
      if (m_tvalid && m_tready) check_output({m_tlast, sps_pkg::pix_t'(m_tdata)});
    end
    mismatches <= errs;
    pending    <= awaited_pixels.size();
  end

endmodule

### tb/sv/five_point_sharpen_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_point_sharpen_filter_tb
// Drives pixel frames of many sizes through the sharpen filter with random
// gaps and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module five_point_sharpen_filter_tb;

  localparam int LIMIT = 1_000_000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [7:0] red, [15:8] green, [23:16] blue
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int            mismatches;
  int            pending;
  int            cycles       = 0;
  int            random_items = 0;
  bit            calm         = 1'b0;
  bit            sender_gaps  = 1'b1;
  sps_pkg::pix_t frame_px[$];

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  five_point_sharpen_filter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  five_point_sharpen_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending)
  );

  // output side back-pressure
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic sps_pkg::pix_t random_pixel();
    logic [23:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = 24'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_pixel(input sps_pkg::pix_t px);
    if (sender_gaps && !calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // row 0 requests give no output, so allow the pipe to drain past the last one
  task automatic settle();
    pause_for_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_px[i]) send_pixel(frame_px[i]);
    frame_px.delete();
  endtask

  task automatic run_random_phase();
    logic [11:0] w;
    logic [12:0] h;
    logic [31:0] junk;
    int          ew;
    int          eh;
    int          count;
    case ($urandom_range(0, 9))
      0:       w = 12'($urandom_range(0, 2));
      1:       w = 12'($urandom_range(17, 64));
      default: w = 12'($urandom_range(3, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       h = 13'($urandom_range(0, 2));
      1:       h = ($urandom_range(0, 1) == 0) ? 13'd4096 : 13'($urandom_range(4097, 8191));
      default: h = 13'($urandom_range(3, 7));
    endcase
    ew = (w < sps_pkg::MIN_DIM) ? sps_pkg::MIN_DIM : w;
    eh = (h < sps_pkg::MIN_DIM) ? sps_pkg::MIN_DIM : h;
    if (eh > 8)
      count = ew * $urandom_range(2, 5) + $urandom_range(0, ew - 1);
    else if (ew > 16)
      count = ew * eh;
    else
      count = ew * eh * $urandom_range(1, 3);
    // broken frame: cut short and restarted by the next register write
    if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
    // keep the whole run near its item budget
    if (count > 420 - random_items) count = 420 - random_items;
    sender_gaps = ($urandom_range(0, 3) != 0);
    junk = ($urandom_range(0, 3) == 0) ? ($urandom() & 32'hFFFF_E000) : '0;
    settle();
    cfg_write(sps_pkg::REG_WIDTH, junk | 32'(w));
    cfg_write(sps_pkg::REG_HEIGHT, junk | 32'(h));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 299) == 0) pause_for_results();
      send_pixel(random_pixel());
    end
    random_items += count;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 640 wide, sent up to two pixels into row 1, where outputs begin
    repeat (642) send_pixel(random_pixel());

    // smallest frame, center saturates high
    settle();
    cfg_write(sps_pkg::REG_WIDTH, 32'd3);
    cfg_write(sps_pkg::REG_HEIGHT, 32'd3);
    for (int i = 0; i < 9; i++) frame_px.push_back((i == 4) ? 24'hFF_FFFF : 24'h00_0000);
    send_frame();
    // center saturates low; hold off mid-frame until everything has come out
    for (int i = 0; i < 4; i++) send_pixel('1);
    pause_for_results();
    send_pixel('0);
    for (int i = 0; i < 4; i++) send_pixel('1);

    // sizes below the minimum clamp to 3x3; in-range sharpening per channel
    settle();
    cfg_write(sps_pkg::REG_WIDTH, 32'd0);
    cfg_write(sps_pkg::REG_HEIGHT, 32'd2);
    for (int i = 0; i < 9; i++) begin
      if (i == 4)
        frame_px.push_back(24'h201818);
      else if (i % 2 == 1)
        frame_px.push_back(24'h080A04);
      else
        frame_px.push_back(random_pixel());
    end
    send_frame();

    // widest setting, partly sent: field maximum clamps to the line store size
    settle();
    sender_gaps = 1'b0;
    cfg_write(sps_pkg::REG_WIDTH, 32'hFFF);
    cfg_write(sps_pkg::REG_HEIGHT, 32'd3);
    repeat (250) send_pixel(random_pixel());

    // tallest frame, partially sent
    settle();
    sender_gaps = 1'b1;
    cfg_write(sps_pkg::REG_WIDTH, 32'd3);
    cfg_write(sps_pkg::REG_HEIGHT, 32'h1FFF);
    repeat (30) send_pixel(random_pixel());

    while (random_items < 380) begin
      if (random_items >= 300) calm = 1'b1;
      run_random_phase();
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
sv/sps_pkg.sv
sv/sps_lane.sv
sv/sps_line_buf.sv
sv/sps_out_queue.sv
sv/five_point_sharpen_filter.sv
tb/sv/five_point_sharpen_checker.sv
tb/sv/five_point_sharpen_filter_tb.sv
